>>> rtl/assert_macros.svh
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define DSKE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked at every clock edge out of reset
`define DSKE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define DSKE_ASSERT(lbl, prop, msg)
`define DSKE_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/dske_pkg.sv
// types and constants of the dual scalar kalman estimator
package dske_pkg;

  localparam int unsigned NUM_W     = 48;  // p * slot count
  localparam int unsigned DEN_W     = 49;  // p * slot count + base noise
  localparam int unsigned GAIN_W    = 17;  // q1.16 gain, 0..1.0
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned CNT_W     = 5;

  localparam logic [GAIN_W-1:0] Q_ONE = 17'h10000;

  // configuration register indexes
  localparam logic [1:0] REG_NOISE_LOAD = 2'd0;
  localparam logic [1:0] REG_NOISE_LOSS = 2'd1;
  localparam logic [1:0] REG_BASE_NOISE = 2'd2;

  typedef struct packed {
    logic [15:0] slot_count;
    logic [19:0] measured_load;
    logic [16:0] measured_loss;
  } in_item_t;

  typedef struct packed {
    logic [31:0] load_estimate;
    logic [31:0] load_variance;
    logic [16:0] loss_estimate;
    logic [31:0] loss_variance;
  } out_item_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/dske_stream_if.sv
// valid/ready stream channel carrying one item
interface dske_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/dske_div.sv
// restoring divider for the kalman gain, one quotient bit per cycle
module dske_div import dske_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output div_rsp_t         rsp_o
);

  logic             busy_q;
  logic             done_q;
  logic             zero_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [GAIN_W-1:0] quot_q;

  logic             ge;
  logic [DEN_W:0]   rem_next;

  // numerator never exceeds the denominator, so the top quotient bit is 2^16
  assign ge       = rem_q >= {1'b0, den_q};
  assign rem_next = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, num_i};
      den_q  <= den_i;
      zero_q <= (den_i == '0);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= {rem_next[DEN_W-1:0], 1'b0};
      quot_q <= {quot_q[GAIN_W-2:0], ge};
    end
  end

  // zero denominator means zero gain
  assign rsp_o.done = done_q;
  assign rsp_o.quot = zero_q ? '0 : quot_q;

endmodule

>>> rtl/dual_scalar_kalman_estimator_unit.sv
// top level of the dual scalar kalman estimator
//
// in_i carries one frame per item: slot count, instant load and instant loss.
// res_o carries the updated load and loss estimates and their variances.
// an item with a zero slot count is taken and gives no result.
// the three noise registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; index 3 is ignored. the user must write them only while the
// block is idle; the block itself does not enforce it. each item runs both
// filters one after the other on shared hardware: one 32x17 multiplier and
// one restoring divider that makes one gain bit a cycle. a filter steps
// through predict, p*N, denominator, the divider wait, gain*diff, value
// update and variance; the result reaches the output register in the same
// cycle that in_i.ready returns, and no new item is taken until then. the
// 17-step divide runs once per filter.
// a finished result sits in the output register while the next item is
// taken; if it is still not taken when the next one is done, the block
// waits holding the new result until res_o.ready.
// reset sets both estimates to 0, both variances to 1.0 and the registers
// to their defaults.
`include "assert_macros.svh"

module dual_scalar_kalman_estimator_unit import dske_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  dske_stream_if.sink         in_i,
  dske_stream_if.source       res_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_PRED = 9'b000000010,  // p = e + q, saturated
    ST_MULN = 9'b000000100,  // p * slot count
    ST_DEN  = 9'b000001000,  // start divider, take |m - v|
    ST_DIV  = 9'b000010000,  // wait for the gain
    ST_MULG = 9'b000100000,  // gain * diff
    ST_UPD  = 9'b001000000,  // new value, (1 - gain) * p
    ST_ERR  = 9'b010000000,  // new variance
    ST_OUT  = 9'b100000000   // hand the result to the output register
  } state_e;

  state_e state_q, state_d;
  logic   sel_q;  // 0: load filter, 1: loss filter

  // configuration
  logic [31:0] noise_load_q, noise_loss_q, base_noise_q;

  // filter state
  logic [31:0] load_value_q, load_error_q, loss_error_q;
  logic [16:0] loss_value_q;

  // item and working registers
  logic [15:0]       slot_q;
  logic [19:0]       meas_load_q;
  logic [16:0]       meas_loss_q;
  logic [31:0]       p_q;
  logic [31:0]       diff_q;
  logic              up_q;
  logic [GAIN_W-1:0] gain_q;
  logic [48:0]       prod_q;

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  // current filter view
  logic [31:0] cur_value, cur_err, cur_noise, cur_meas;
  logic [32:0] pred_sum;
  logic [31:0] delta, new_value;
  logic [16:0] new_loss;

  // shared multiplier
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_res;

  // divider
  logic             div_start;
  logic [DEN_W-1:0] div_den;
  div_rsp_t         div_rsp;

  logic in_acc, out_free;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  assign cur_value = sel_q ? {15'b0, loss_value_q} : load_value_q;
  assign cur_err   = sel_q ? loss_error_q : load_error_q;
  assign cur_noise = sel_q ? noise_loss_q : noise_load_q;
  assign cur_meas  = sel_q ? {15'b0, meas_loss_q} : {12'b0, meas_load_q};

  assign pred_sum  = {1'b0, cur_err} + {1'b0, cur_noise};

  // the step stays between old value and measurement, so no wrap
  assign delta     = prod_q[47:16];
  assign new_value = up_q ? (cur_value + delta) : (cur_value - delta);
  assign new_loss  = (new_value > {15'b0, Q_ONE}) ? Q_ONE : new_value[16:0];

  always_comb begin
    mul_a = p_q;
    mul_b = {1'b0, slot_q};
    unique case (state_q)
      ST_MULG: begin
        mul_a = diff_q;
        mul_b = gain_q;
      end
      ST_UPD: begin
        mul_a = p_q;
        mul_b = Q_ONE - gain_q;
      end
      default: begin
        mul_a = p_q;
        mul_b = {1'b0, slot_q};
      end
    endcase
  end

  assign mul_res = {17'b0, mul_a} * {32'b0, mul_b};

  assign div_start = (state_q == ST_DEN);
  assign div_den   = {1'b0, prod_q[NUM_W-1:0]} + {17'b0, base_noise_q};

  dske_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q[NUM_W-1:0]),
    .den_i  (div_den),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && in_i.data.slot_count != '0) state_d = ST_PRED;
      ST_PRED: state_d = ST_MULN;
      ST_MULN: state_d = ST_DEN;
      ST_DEN:  state_d = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_d = ST_MULG;
      ST_MULG: state_d = ST_UPD;
      ST_UPD:  state_d = ST_ERR;
      ST_ERR:  state_d = sel_q ? ST_OUT : ST_PRED;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // control, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sel_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      noise_load_q <= 32'd655;
      noise_loss_q <= 32'd655;
      base_noise_q <= 32'd65536;
      load_value_q <= '0;
      load_error_q <= 32'd65536;
      loss_value_q <= '0;
      loss_error_q <= 32'd65536;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NOISE_LOAD: noise_load_q <= cfg_data_i;
          REG_NOISE_LOSS: noise_loss_q <= cfg_data_i;
          REG_BASE_NOISE: base_noise_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_UPD) begin
        if (sel_q) loss_value_q <= new_loss;
        else       load_value_q <= new_value;
      end

      if (state_q == ST_ERR) begin
        if (sel_q) loss_error_q <= prod_q[47:16];
        else       load_error_q <= prod_q[47:16];
        sel_q <= 1'b1;
      end

      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        sel_q       <= 1'b0;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q      <= in_i.data.slot_count;
      meas_load_q <= in_i.data.measured_load;
      meas_loss_q <= in_i.data.measured_loss;
    end
    if (state_q == ST_PRED) begin
      p_q <= pred_sum[32] ? '1 : pred_sum[31:0];
    end
    if (state_q == ST_MULN || state_q == ST_MULG || state_q == ST_UPD) begin
      prod_q <= mul_res;
    end
    if (state_q == ST_DEN) begin
      up_q   <= cur_meas >= cur_value;
      diff_q <= (cur_meas >= cur_value) ? (cur_meas - cur_value) : (cur_value - cur_meas);
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      gain_q <= div_rsp.quot;
    end
    if (state_q == ST_OUT && out_free) begin
      out_q.load_estimate <= load_value_q;
      out_q.load_variance <= load_error_q;
      out_q.loss_estimate <= loss_value_q;
      out_q.loss_variance <= loss_error_q;
    end
  end

  `DSKE_ASSERT(a_loss_in_range, loss_value_q <= Q_ONE, "loss estimate above 1.0")
  `DSKE_ASSERT_IMP(a_gain_in_range, state_q == ST_MULG, gain_q <= Q_ONE, "gain above 1.0")
  `DSKE_ASSERT_IMP(a_pred_not_below, state_q == ST_MULN, p_q >= cur_err, "prediction below variance")
  `DSKE_ASSERT_IMP(a_result_from_out, $rose(out_valid_q), $past(state_q == ST_OUT), "result outside out step")

endmodule

>>> bench/dske_frame_checker.sv
// frame checker: tracks both filters and compares every estimate item
module dske_frame_checker import dske_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        frame_valid_i,
  input  logic        frame_ready_i,
  input  in_item_t    frame_i,
  input  logic        est_valid_i,
  input  logic        est_ready_i,
  input  out_item_t   est_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned outstanding_o,
  output int unsigned mismatch_count_o
);

  localparam logic [31:0] NOISE_RESET = 32'd655;
  localparam logic [31:0] BASE_RESET  = 32'd65536;
  localparam logic [63:0] SAT32       = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] GAIN_ONE    = {47'd0, Q_ONE};

  logic [31:0] noise_load, noise_loss, base_noise;
  logic [31:0] load_est, load_err, loss_est, loss_err;
  out_item_t   estimates_q[$];
  int unsigned mismatches = 0;

  // one scalar filter step: predict, gain by division, move toward the measurement
  function automatic void kalman_update(inout logic [31:0] est, inout logic [31:0] err,
                                        input logic [31:0] meas, input logic [31:0] noise,
                                        input logic [15:0] slots);
    logic [63:0] prior, scaled, denom, gain, step;
    prior = {32'd0, err} + {32'd0, noise};
    if (prior > SAT32) prior = SAT32;
    scaled = prior * {48'd0, slots};
    denom  = scaled + {32'd0, base_noise};
    gain   = (denom == '0) ? '0 : (scaled << 16) / denom;
    if (gain > GAIN_ONE) gain = GAIN_ONE;
    // truncation pulls toward the old estimate
    if (meas >= est) begin
      step = (gain * ({32'd0, meas} - {32'd0, est})) >> 16;
      est  = est + step[31:0];
    end else begin
      step = (gain * ({32'd0, est} - {32'd0, meas})) >> 16;
      est  = est - step[31:0];
    end
    step = ((GAIN_ONE - gain) * prior) >> 16;
    err  = step[31:0];
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      noise_load = NOISE_RESET;
      noise_loss = NOISE_RESET;
      base_noise = BASE_RESET;
      load_est   = '0;
      load_err   = 32'h0001_0000;
      loss_est   = '0;
      loss_err   = 32'h0001_0000;
      estimates_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NOISE_LOAD: noise_load = cfg_data_i;
          REG_NOISE_LOSS: noise_loss = cfg_data_i;
          REG_BASE_NOISE: base_noise = cfg_data_i;
          default: ;
        endcase
      end
      // results first: a result never belongs to a frame taken at the same edge
      if (est_valid_i && est_ready_i) begin
        if (estimates_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual %h", $realtime, est_i);
          mismatches++;
        end else begin
          want = estimates_q.pop_front();
          check_field("load_estimate", want.load_estimate, est_i.load_estimate);
          check_field("load_variance", want.load_variance, est_i.load_variance);
          check_field("loss_estimate", {15'd0, want.loss_estimate},
                      {15'd0, est_i.loss_estimate});
          check_field("loss_variance", want.loss_variance, est_i.loss_variance);
        end
      end
      // zero slot count: frame dropped, filters untouched
      if (frame_valid_i && frame_ready_i && frame_i.slot_count != '0) begin
        kalman_update(load_est, load_err, {12'd0, frame_i.measured_load}, noise_load,
                      frame_i.slot_count);
        kalman_update(loss_est, loss_err, {15'd0, frame_i.measured_loss}, noise_loss,
                      frame_i.slot_count);
        if (loss_est > {15'd0, Q_ONE}) loss_est = {15'd0, Q_ONE};
        want.load_estimate = load_est;
        want.load_variance = load_err;
        want.loss_estimate = loss_est[16:0];
        want.loss_variance = loss_err;
        estimates_q.push_back(want);
      end
    end
    outstanding_o    <= estimates_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

>>> bench/dual_scalar_kalman_estimator_unit_tb.sv
// testbench top: frame stimulus, register phases and the verdict
//
// the block runs two scalar kalman filters (offered load and loss ratio) per
// frame item and returns one estimate item per frame with a nonzero slot count.
// a checker beside the block predicts every estimate and compares it; this
// module only makes stimulus and reports the outcome.
//
// plan of the run
//   directed frames at reset register values: skipped frames, one and max
//   slots, measurement extremes, loss above 1.0
//   zero noise and zero base noise: full gain, then a zero denominator
//   all registers at max: predicted variance saturates
//   six random phases with different register settings
// noise registers only change while nothing is in flight, and after the
// last estimate a settle gap covers a trailing skipped frame still inside
// the block
module dual_scalar_kalman_estimator_unit_tb;
  import dske_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned SETTLE_CYCLES    = 64;    // longer than one full frame
  localparam int unsigned HOLD_CYCLES      = 600;   // long receiver hold-off
  localparam int unsigned RANDOM_PER_PHASE = 140;
  localparam int unsigned NUM_PHASES       = 6;
  localparam logic [1:0]  REG_UNUSED       = 2'd3;  // write must be ignored
  localparam logic [31:0] NOISE_RESET      = 32'd655;
  localparam logic [31:0] BASE_RESET       = 32'd65536;
  localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  logic        quiet = 1'b0;     // no idling on either side
  logic        hold_arm = 1'b0;  // asks the receiver for one long hold-off
  int unsigned outstanding;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;

  dske_stream_if #(.payload_t(in_item_t))  frame_ch ();
  dske_stream_if #(.payload_t(out_item_t)) est_ch ();

  always #2 clk_i = ~clk_i;

  dual_scalar_kalman_estimator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (frame_ch),
    .res_o      (est_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  dske_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_valid_i    (frame_ch.valid),
    .frame_ready_i    (frame_ch.ready),
    .frame_i          (frame_ch.data),
    .est_valid_i      (est_ch.valid),
    .est_ready_i      (est_ch.ready),
    .est_i            (est_ch.data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatch_count)
  );

  // hard stop in case the block hangs or drops an estimate
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // estimate receiver: random stalls, plus one long hold-off on request so the
  // output register and the held result fill and the block stops taking frames
  initial begin
    int unsigned hold_left;
    logic        hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    est_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_arm && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        est_ch.ready <= 1'b0;
      end else begin
        est_ch.ready <= rst_ni && (quiet || $urandom_range(99) >= 26);
      end
    end
  end

  // offer one frame and hold it until taken, then maybe leave a gap
  task automatic send_frame(input in_item_t frame);
    frame_ch.valid <= 1'b1;
    frame_ch.data  <= frame;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    // gaps of up to a whole frame time so they land on every filter stage
    if (!quiet && $urandom_range(99) < 26) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(60, 1)) @(posedge clk_i);
    end
  endtask

  // sender pause until every pending estimate has come back
  task automatic wait_results();
    frame_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // drain, then let a trailing skipped frame leave the block
  task automatic finish_phase();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one write per cycle, the ignored index first
  task automatic set_noise_regs(input logic [31:0] load_q, input logic [31:0] loss_q,
                                input logic [31:0] base_r);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_UNUSED;
    cfg_data <= $urandom;
    @(posedge clk_i);
    cfg_idx  <= REG_NOISE_LOAD;
    cfg_data <= load_q;
    @(posedge clk_i);
    cfg_idx  <= REG_NOISE_LOSS;
    cfg_data <= loss_q;
    @(posedge clk_i);
    cfg_idx  <= REG_BASE_NOISE;
    cfg_data <= base_r;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // mostly small slot counts, some skips, some anywhere in the 16-bit range
  function automatic in_item_t random_frame();
    in_item_t    frame;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6)       frame.slot_count = '0;
    else if (pick < 70) frame.slot_count = 16'($urandom_range(64, 1));
    else if (pick < 76) frame.slot_count = 16'hFFFF;
    else                frame.slot_count = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 10)      frame.measured_load = '0;
    else if (pick < 20) frame.measured_load = 20'hFFFFF;
    else                frame.measured_load = 20'($urandom);
    // loss mostly within 0..1.0, sometimes above
    pick = $urandom_range(99);
    if (pick < 10)      frame.measured_loss = '0;
    else if (pick < 20) frame.measured_loss = 17'h10000;
    else if (pick < 80) frame.measured_loss = 17'($urandom_range(65536));
    else                frame.measured_loss = 17'($urandom);
    return frame;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    frame_ch.valid = 1'b0;
    frame_ch.data  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: skips, slot extremes, measurement extremes
    send_frame(in_item_t'{16'd0, 20'hFFFFF, 17'h1FFFF});
    send_frame(in_item_t'{16'd1, 20'h10000, 17'h08000});
    send_frame(in_item_t'{16'hFFFF, 20'hFFFFF, 17'h10000});
    send_frame(in_item_t'{16'd1, 20'h00000, 17'h00000});
    send_frame(in_item_t'{16'hFFFF, 20'h00000, 17'h1FFFF});
    send_frame(in_item_t'{16'd0, 20'h00000, 17'h00000});
    send_frame(in_item_t'{16'hFFFF, 20'hFFFFF, 17'h1FFFF});
    send_frame(in_item_t'{16'd1, 20'h00001, 17'h00001});
    finish_phase();

    // no noise at all: full gain clears the variance, then the denominator is zero
    set_noise_regs('0, '0, '0);
    send_frame(in_item_t'{16'd3, 20'h12345, 17'h04000});
    send_frame(in_item_t'{16'd7, 20'hFFFFF, 17'h1FFFF});
    send_frame(in_item_t'{16'hFFFF, 20'h00000, 17'h00000});
    send_frame(in_item_t'{16'd0, 20'h54321, 17'h0C000});
    finish_phase();

    // everything at max: predicted variance saturates
    set_noise_regs(ALL_ONES, ALL_ONES, ALL_ONES);
    send_frame(in_item_t'{16'hFFFF, 20'hFFFFF, 17'h1FFFF});
    send_frame(in_item_t'{16'd1, 20'h00000, 17'h00000});
    send_frame(in_item_t'{16'd1, 20'h80000, 17'h10000});
    send_frame(in_item_t'{16'hFFFF, 20'h00000, 17'h1FFFF});
    finish_phase();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // long stretch with no idling in the first phase only
      quiet = (phase == 0);
      case (phase)
        0: set_noise_regs(NOISE_RESET, NOISE_RESET, BASE_RESET);
        1: set_noise_regs($urandom, $urandom, $urandom);
        2: set_noise_regs($urandom_range(4095), $urandom_range(4095),
                          $urandom_range(65535));
        3: set_noise_regs($urandom_range(255), $urandom_range(255), '0);
        4: set_noise_regs(ALL_ONES, $urandom_range(65535), ALL_ONES);
        default: set_noise_regs('0, '0, $urandom_range(1 << 20));
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 1 && n == 20) hold_arm <= 1'b1;
        if (phase == 2 && n == 70) wait_results();
        send_frame(random_frame());
      end
      finish_phase();
    end
    quiet = 1'b0;

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> dual_scalar_kalman_estimator_unit.f
+incdir+rtl
rtl/dske_pkg.sv
rtl/dske_stream_if.sv
rtl/dske_div.sv
rtl/dual_scalar_kalman_estimator_unit.sv
bench/dske_frame_checker.sv
bench/dual_scalar_kalman_estimator_unit_tb.sv
